[rtl/core/pbd_pkg.sv]
package pbd_pkg;

  localparam int SAMPLE_W = 10;
  localparam int DEV_W    = 8;
  localparam int MEAN_W   = 11;
  localparam int DIFF_W   = SAMPLE_W + 2;

  localparam int WINDOW_DEPTH_DEF = 128;

  localparam logic [MEAN_W-1:0]       MEAN_RESET = 11'd1024;
  localparam logic signed [DEV_W-1:0] DEV_MAX    = 8'sd127;
  localparam logic signed [DEV_W-1:0] DEV_MIN    = -8'sd128;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } pbd_state_e;

  typedef struct packed {
    logic load;     // capture the sample word
    logic update;   // deviation, mean, history write, peak step
    logic scan_rd;  // read one history entry during a rescan
    logic finish;   // beat test and result load
  } pbd_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_last;
    logic out_free;
  } pbd_status_t;

endpackage

[rtl/core/pbd_ctrl.sv]
module pbd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  pbd_pkg::pbd_status_t status_i,
  output pbd_pkg::pbd_cmd_t    cmd_o
);
  import pbd_pkg::*;

  pbd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = status_i.need_scan ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (status_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last read word is compared here
        state_d = S_DONE;
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/pbd_datapath.sv]
module pbd_datapath #(
  parameter int WindowDepth = pbd_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pbd_pkg::pbd_cmd_t                    cmd_i,
  output pbd_pkg::pbd_status_t                 status_o,
  input  logic [pbd_pkg::SAMPLE_W-1:0]         sample_i,
  input  logic                                 out_stall_i,
  output logic                                 out_valid_o,
  output logic                                 beat_o,
  output logic signed [pbd_pkg::DEV_W-1:0]     deviation_o,
  output logic signed [pbd_pkg::DEV_W-1:0]     window_peak_o
);
  import pbd_pkg::*;

  localparam int IdxW  = $clog2(WindowDepth);
  localparam int FillW = $clog2(WindowDepth + 1);
  localparam logic [IdxW-1:0]  LastIdx = IdxW'(WindowDepth - 1);
  localparam logic [FillW-1:0] FillMax = FillW'(WindowDepth);
  localparam logic [FillW:0]   FillCmp = (FillW + 1)'(WindowDepth);

  logic signed [DEV_W-1:0] hist_mem [WindowDepth];

  logic [SAMPLE_W-1:0]     sample_q;
  logic [MEAN_W-1:0]       mean_q;
  logic                    pending_q;
  logic signed [DEV_W-1:0] dev_q;
  logic signed [DEV_W-1:0] peak_q;
  logic [IdxW-1:0]         age_q;
  logic [IdxW-1:0]         wr_ptr_q;
  logic [FillW-1:0]        fill_q;
  logic [IdxW-1:0]         rd_ptr_q;
  logic [IdxW-1:0]         scan_cnt_q;
  logic signed [DEV_W-1:0] rd_data_q;
  logic [IdxW-1:0]         rd_idx_q;
  logic                    rd_ok_q;
  logic                    rd_vld_q;
  logic                    out_valid_q;
  logic                    out_beat_q;
  logic signed [DEV_W-1:0] out_dev_q;
  logic signed [DEV_W-1:0] out_peak_q;

  logic signed [DIFF_W-1:0] diff_c;
  logic signed [DEV_W-1:0]  dev_c;
  logic [MEAN_W-1:0]        twice_c;
  logic [IdxW-1:0]          wr_ptr_nx;
  logic [IdxW-1:0]          rd_ptr_nx;
  logic signed [DEV_W-1:0]  scan_val_c;
  logic                     scan_take_c;
  logic                     beat_c;
  logic                     out_free_c;

  always_comb begin
    diff_c = $signed({2'b00, sample_q}) - $signed({2'b00, mean_q[MEAN_W-1:1]});
    if (diff_c > DEV_MAX) begin
      dev_c = DEV_MAX;
    end else if (diff_c < DEV_MIN) begin
      dev_c = DEV_MIN;
    end else begin
      dev_c = diff_c[DEV_W-1:0];
    end
  end

  assign twice_c     = {sample_q, 1'b0};
  assign wr_ptr_nx   = (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
  assign rd_ptr_nx   = (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
  // slots never written since reset read as zero
  assign scan_val_c  = rd_ok_q ? rd_data_q : '0;
  assign scan_take_c = (rd_idx_q == '0) || (scan_val_c >= peak_q);
  assign beat_c      = !pending_q && ($signed({dev_q, 1'b0}) > $signed({peak_q[DEV_W-1], peak_q}));
  assign out_free_c  = !out_valid_q || !out_stall_i;

  assign status_o.need_scan = !(dev_c > peak_q) && (age_q == '0);
  assign status_o.scan_last = (scan_cnt_q == LastIdx);
  assign status_o.out_free  = out_free_c;

  // history memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      hist_mem[wr_ptr_q] <= dev_c;
    end
    if (cmd_i.scan_rd) begin
      rd_data_q <= hist_mem[rd_ptr_q];
      rd_idx_q  <= scan_cnt_q;
      rd_ok_q   <= ((FillW + 1)'(FillW'(scan_cnt_q)) + (FillW + 1)'(fill_q)) >= FillCmp;
    end
  end

  // payload words
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q <= sample_i;
    end
    if (cmd_i.update) begin
      dev_q    <= dev_c;
      rd_ptr_q <= wr_ptr_nx;
    end else if (cmd_i.scan_rd) begin
      rd_ptr_q <= rd_ptr_nx;
    end
    if (cmd_i.update) begin
      scan_cnt_q <= '0;
    end else if (cmd_i.scan_rd) begin
      scan_cnt_q <= scan_cnt_q + 1'b1;
    end
    if (cmd_i.finish) begin
      out_beat_q <= beat_c;
      out_dev_q  <= dev_q;
      out_peak_q <= peak_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q      <= MEAN_RESET;
      pending_q   <= 1'b0;
      peak_q      <= '0;
      age_q       <= '0;
      wr_ptr_q    <= '0;
      fill_q      <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_rd;
      if (cmd_i.update) begin
        wr_ptr_q <= wr_ptr_nx;
        if (fill_q != FillMax) begin
          fill_q <= fill_q + 1'b1;
        end
        if (twice_c > mean_q) begin
          mean_q <= mean_q + 1'b1;
        end else if (twice_c < mean_q) begin
          mean_q    <= mean_q - 1'b1;
          pending_q <= 1'b0;
        end
        if (dev_c > peak_q) begin
          peak_q <= dev_c;
          age_q  <= LastIdx;
        end else if (age_q != '0) begin
          age_q <= age_q - 1'b1;
        end
      end
      // rescan: oldest to newest, ties go to the later entry
      if (rd_vld_q && scan_take_c) begin
        peak_q <= scan_val_c;
        age_q  <= rd_idx_q;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
        if (beat_c) begin
          pending_q <= 1'b1;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign beat_o        = out_beat_q;
  assign deviation_o   = out_dev_q;
  assign window_peak_o = out_peak_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillMax)
    else $error("history fill count beyond window depth");

  a_age_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    age_q <= LastIdx)
    else $error("peak index outside the window");

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q <= LastIdx) && (!rd_vld_q || rd_idx_q <= LastIdx))
    else $error("history pointer out of range");

endmodule

[rtl/core/pulse_beat_detector_unit.sv]
// Sequence: a sample word is taken in S_IDLE and processed in S_UPDATE; S_DONE loads
//   the result once the output is free, after a rescan (S_SCAN, S_DRAIN) if the peak
//   leaves the window. A new sample is taken only after the last result is loaded;
//   the rescan reads the history memory one entry a cycle through its single read port.
// Reset: asynchronous, active low; mean to 1024, peak and beat mark cleared;
//   history entries not yet written read as zero, so no clearing pass is needed.
module pulse_beat_detector_unit #(
  parameter int WindowDepth = pbd_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [pbd_pkg::SAMPLE_W-1:0]     sample_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             beat_o,
  output logic signed [pbd_pkg::DEV_W-1:0] deviation_o,
  output logic signed [pbd_pkg::DEV_W-1:0] window_peak_o
);
  import pbd_pkg::*;

  pbd_cmd_t    cmd;
  pbd_status_t status;

  pbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pbd_datapath #(
    .WindowDepth (WindowDepth)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .sample_i      (sample_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .beat_o        (beat_o),
    .deviation_o   (deviation_o),
    .window_peak_o (window_peak_o)
  );

endmodule
